/* hw/rtl/ktc_pkg.sv */
// ----------------------------------------------------------------------------
// ktc_pkg
// Shared widths, character classes, status codes and the signature table
// of the key token classifier.
// ----------------------------------------------------------------------------
package ktc_pkg;

    // field widths
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 8;
    localparam int CLS_W     = 7;
    localparam int STAT_W    = 2;
    localparam int KIND_W    = 3;
    localparam int PLEN_W    = 4;

    // signature table shape
    localparam int NUM_SIGS  = 6;
    localparam int SIG_CHARS = 8;

    localparam logic [CHAR_W-1:0] SEP_RESET = 8'd44;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 8'd255;

    // character class bits
    localparam logic [CLS_W-1:0] CLS_DIGIT   = 7'h01;
    localparam logic [CLS_W-1:0] CLS_AF_LO   = 7'h02;
    localparam logic [CLS_W-1:0] CLS_GZ_LO   = 7'h04;
    localparam logic [CLS_W-1:0] CLS_AF_UP   = 7'h08;
    localparam logic [CLS_W-1:0] CLS_GZ_UP   = 7'h10;
    localparam logic [CLS_W-1:0] CLS_BRACKET = 7'h20;
    localparam logic [CLS_W-1:0] CLS_OTHER   = 7'h40;

    // verdict status codes
    typedef enum logic [STAT_W-1:0] {
        ST_MATCH   = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    // one signature: length range, allowed classes, literal prefix
    typedef struct packed {
        logic [LEN_W-1:0]                 lo_len;
        logic [LEN_W-1:0]                 hi_len;
        logic [CLS_W-1:0]                 allowed;
        logic [PLEN_W-1:0]                plen;
        logic [0:SIG_CHARS-1][CHAR_W-1:0] text;
    } t_sig;

    localparam t_sig SIG_TABLE [NUM_SIGS] = '{
        // slip77
        '{lo_len: 8'd72, hi_len: 8'd72,
          allowed: CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO | CLS_BRACKET, plen: 4'd6,
          text: '{"s", "l", "i", "p", "7", "7", 8'h00, 8'h00}},
        // xpub
        '{lo_len: 8'd111, hi_len: 8'd112,
          allowed: CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO | CLS_AF_UP | CLS_GZ_UP,
          plen: 4'd4,
          text: '{"x", "p", "u", "b", 8'h00, 8'h00, 8'h00, 8'h00}},
        // xprv
        '{lo_len: 8'd111, hi_len: 8'd112,
          allowed: CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO | CLS_AF_UP | CLS_GZ_UP,
          plen: 4'd4,
          text: '{"x", "p", "r", "v", 8'h00, 8'h00, 8'h00, 8'h00}},
        // elip151
        '{lo_len: 8'd7, hi_len: 8'd7,
          allowed: CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO, plen: 4'd7,
          text: '{"e", "l", "i", "p", "1", "5", "1", 8'h00}},
        // 64-hex private key
        '{lo_len: 8'd64, hi_len: 8'd64,
          allowed: CLS_DIGIT | CLS_AF_LO, plen: 4'd0,
          text: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        // 66-hex public key
        '{lo_len: 8'd66, hi_len: 8'd66,
          allowed: CLS_DIGIT | CLS_AF_LO, plen: 4'd0,
          text: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}
    };

    // class of one raw byte
    function automatic logic [CLS_W-1:0] class_of(input logic [CHAR_W-1:0] c);
        logic [CLS_W-1:0] cls;
        if (c >= "0" && c <= "9") begin
            cls = CLS_DIGIT;
        end else if (c >= "a" && c <= "f") begin
            cls = CLS_AF_LO;
        end else if (c >= "g" && c <= "z") begin
            cls = CLS_GZ_LO;
        end else if (c >= "A" && c <= "F") begin
            cls = CLS_AF_UP;
        end else if (c >= "G" && c <= "Z") begin
            cls = CLS_GZ_UP;
        end else if (c == "(" || c == ")") begin
            cls = CLS_BRACKET;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

/* hw/rtl/ktc_if.sv */
// ----------------------------------------------------------------------------
// ktc_if
// Valid/ready channels of the key token classifier: separator write,
// character input and verdict output.
// ----------------------------------------------------------------------------

// separator register write channel
interface ktc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ktc_pkg::CHAR_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// character input channel
interface ktc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ktc_pkg::CHAR_W-1:0]  char_code;
    logic                        end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// verdict output channel
interface ktc_out_if;
    logic                        valid;
    logic                        ready;
    logic [ktc_pkg::STAT_W-1:0]  status;
    logic [ktc_pkg::KIND_W-1:0]  key_kind;
    logic [ktc_pkg::LEN_W-1:0]   token_length;
    logic [ktc_pkg::CLS_W-1:0]   class_mask;

    modport source (output valid, output status, output key_kind,
                    output token_length, output class_mask, input ready);
    modport sink   (input valid, input status, input key_kind,
                    input token_length, input class_mask, output ready);
endinterface

/* hw/rtl/key_token_classifier_core.sv */
// ----------------------------------------------------------------------------
// key_token_classifier_core
// Builds tokens from a character stream and classifies each closed token
// against a fixed table of key signatures.
// ----------------------------------------------------------------------------
// Usage:
//   i_in    one character request per cycle (char_code, end_of_text). A byte
//           other than the separator extends the current token; the separator
//           or end_of_text closes it and produces one verdict.
//   o_out   one verdict per closed token: status, key_kind, token_length and
//           class_mask, held in an output register until taken.
//   i_cfg   writes the separator byte; always ready, used while idle.
// Latency: a verdict is valid in the cycle after its closing request is
//   accepted. Throughput is one request per cycle, set by the single token
//   state update and the table match between the token registers and the
//   output register.
// Stall: while a verdict waits and o_out.ready is low, i_in.ready drops;
//   when the verdict is taken the next request is accepted in the same edge.
// Reset: token length, classes and prefix store clear, the separator returns
//   to ',' and no verdict is pending.
// ----------------------------------------------------------------------------
module key_token_classifier_core #(
    parameter int PREFIX_CHARS = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ktc_cfg_if.sink    i_cfg,
    ktc_in_if.sink     i_in,
    ktc_out_if.source  o_out
);
    import ktc_pkg::*;

    localparam int IDX_W = $clog2(PREFIX_CHARS);

    // token state
    logic [CHAR_W-1:0] r_sep;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [CLS_W-1:0]  r_cls;
    logic [CLS_W-1:0]  n_cls;
    logic [CHAR_W-1:0] r_prefix [PREFIX_CHARS];

    // output register
    logic              r_valid;
    logic              n_valid;
    logic [STAT_W-1:0] r_status;
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_out_len;
    logic [CLS_W-1:0]  r_out_cls;

    logic              w_accept;
    logic              w_close;
    logic              w_store;
    t_status           w_status;
    logic [KIND_W-1:0] w_kind;
    logic [NUM_SIGS-1:0] w_hit;
    logic [CHAR_W-1:0] w_char  [SIG_CHARS];
    logic [SIG_CHARS-1:0] w_avail;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_close     = i_in.end_of_text || (i_in.char_code == r_sep);
    assign w_store     = r_len < LEN_W'(PREFIX_CHARS);

    // separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg.valid) begin
            r_sep <= i_cfg.data;
        end
    end

    // next length and classes of an extended token
    always_comb begin
        n_len = (r_len != LEN_MAX) ? r_len + LEN_W'(1) : r_len;
        n_cls = r_cls | class_of(i_in.char_code);
    end

    // token state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cls <= '0;
            for (int i = 0; i < PREFIX_CHARS; i++) begin
                r_prefix[i] <= '0;
            end
        end else if (w_accept) begin
            if (w_close) begin
                r_len <= '0;
                r_cls <= '0;
                for (int i = 0; i < PREFIX_CHARS; i++) begin
                    r_prefix[i] <= '0;
                end
            end else begin
                r_len <= n_len;
                r_cls <= n_cls;
                if (w_store) begin
                    r_prefix[r_len[IDX_W-1:0]] <= i_in.char_code;
                end
            end
        end
    end

    // stored prefix widened to the table's literal length
    for (genvar g = 0; g < SIG_CHARS; g++) begin : g_char
        if (g < PREFIX_CHARS) begin : g_held
            assign w_char[g]  = r_prefix[g];
            assign w_avail[g] = 1'b1;
        end else begin : g_none
            assign w_char[g]  = '0;
            assign w_avail[g] = 1'b0;
        end
    end

    // per-signature match
    always_comb begin
        for (int k = 0; k < NUM_SIGS; k++) begin
            w_hit[k] = ((r_cls & ~SIG_TABLE[k].allowed) == '0) &&
                       (r_len >= SIG_TABLE[k].lo_len) &&
                       (r_len <= SIG_TABLE[k].hi_len);
            for (int i = 0; i < SIG_CHARS; i++) begin
                if (PLEN_W'(i) < SIG_TABLE[k].plen) begin
                    if (!w_avail[i] || (w_char[i] != SIG_TABLE[k].text[i])) begin
                        w_hit[k] = 1'b0;
                    end
                end
            end
        end
    end

    // first matching entry wins
    always_comb begin
        w_status = ST_NOMATCH;
        w_kind   = '0;
        if (r_len == '0) begin
            w_status = ST_EMPTY;
        end else begin
            for (int k = NUM_SIGS - 1; k >= 0; k--) begin
                if (w_hit[k]) begin
                    w_status = ST_MATCH;
                    w_kind   = KIND_W'(k);
                end
            end
        end
    end

    // output register control
    always_comb begin
        if (w_accept && w_close) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // verdict payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_close) begin
            r_status  <= w_status;
            r_kind    <= w_kind;
            r_out_len <= r_len;
            r_out_cls <= r_cls;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_status;
    assign o_out.key_kind     = r_kind;
    assign o_out.token_length = r_out_len;
    assign o_out.class_mask   = r_out_cls;

endmodule

/* verif/key_token_classifier_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_token_classifier_core_tb
// Streams character requests into the classifier and checks every verdict
// against a cycle-free model of the token state and the signature table.
// Directed tokens come first, then random well-formed, broken and noise
// tokens under several separator settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module key_token_classifier_core_tb;
    import ktc_pkg::*;

    localparam int PREFIX_CHARS = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4;

    // allowed class sets and lengths of the signatures
    localparam logic [CLS_W-1:0] SLIP_CLS = CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO | CLS_BRACKET;
    localparam logic [CLS_W-1:0] B58_CLS  = CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO | CLS_AF_UP
                                            | CLS_GZ_UP;
    localparam logic [CLS_W-1:0] ELIP_CLS = CLS_DIGIT | CLS_AF_LO | CLS_GZ_LO;
    localparam logic [CLS_W-1:0] HEX_CLS  = CLS_DIGIT | CLS_AF_LO;
    localparam logic [CLS_W-1:0] ANY_CLS  = 7'h7F;
    localparam int SLIP_LEN     = 72;
    localparam int EXT_LEN_LO   = 111;
    localparam int EXT_LEN_HI   = 112;
    localparam int ELIP_LEN     = 7;
    localparam int HEX_PRIV_LEN = 64;
    localparam int HEX_PUB_LEN  = 66;

    typedef enum logic [KIND_W-1:0] {
        KIND_SLIP77   = 3'd0,
        KIND_XPUB     = 3'd1,
        KIND_XPRV     = 3'd2,
        KIND_ELIP151  = 3'd3,
        KIND_HEX_PRIV = 3'd4,
        KIND_HEX_PUB  = 3'd5
    } key_kind_e;

    typedef enum int {
        TOK_SLIP77, TOK_XPUB, TOK_XPRV, TOK_ELIP151, TOK_HEX_PRIV, TOK_HEX_PUB,
        TOK_SHORT, TOK_NOISE, TOK_LONG
    } token_shape_e;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_e;

    typedef struct packed {
        t_status            status;
        logic [KIND_W-1:0]  kind;
        logic [LEN_W-1:0]   len;
        logic [CLS_W-1:0]   mask;
    } verdict_t;

    logic clk;
    logic rst_n;

    ktc_cfg_if cfg_ch();
    ktc_in_if  in_ch();
    ktc_out_if out_ch();

    key_token_classifier_core #(
        .PREFIX_CHARS(PREFIX_CHARS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // token state as the block should hold it
    logic [CHAR_W-1:0] sep_char;
    logic [LEN_W-1:0]  tok_len;
    logic [CLS_W-1:0]  tok_classes;
    logic [CHAR_W-1:0] tok_prefix [PREFIX_CHARS];

    verdict_t verdict_q [$];

    int items_sent;
    int verdicts_made;
    int fail_count;
    int gap_max;
    int burst_left;
    int hold_len;
    rx_mode_e rx_mode;

    // clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // class of one raw byte
    function automatic logic [CLS_W-1:0] char_class(logic [CHAR_W-1:0] c);
        if (c inside {["0":"9"]}) return CLS_DIGIT;
        if (c inside {["a":"f"]}) return CLS_AF_LO;
        if (c inside {["g":"z"]}) return CLS_GZ_LO;
        if (c inside {["A":"F"]}) return CLS_AF_UP;
        if (c inside {["G":"Z"]}) return CLS_GZ_UP;
        if (c inside {"(", ")"}) return CLS_BRACKET;
        return CLS_OTHER;
    endfunction

    // literal prefix test against the stored first characters
    function automatic bit prefix_is(string lit);
        for (int i = 0; i < lit.len(); i++) begin
            if (i >= PREFIX_CHARS) return 1'b0;
            if (tok_prefix[i] != lit[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit sig_hit(int lo, int hi, logic [CLS_W-1:0] allowed, string lit);
        return ((tok_classes & ~allowed) == '0) && (tok_len >= lo) && (tok_len <= hi)
               && prefix_is(lit);
    endfunction

    // verdict of the token held so far, table walked in order
    function automatic verdict_t classify_token();
        verdict_t v;
        v.len    = tok_len;
        v.mask   = tok_classes;
        v.kind   = KIND_SLIP77;
        v.status = ST_MATCH;
        if (tok_len == 0) begin
            v.status = ST_EMPTY;
        end else if (sig_hit(SLIP_LEN, SLIP_LEN, SLIP_CLS, "slip77")) begin
            v.kind = KIND_SLIP77;
        end else if (sig_hit(EXT_LEN_LO, EXT_LEN_HI, B58_CLS, "xpub")) begin
            v.kind = KIND_XPUB;
        end else if (sig_hit(EXT_LEN_LO, EXT_LEN_HI, B58_CLS, "xprv")) begin
            v.kind = KIND_XPRV;
        end else if (sig_hit(ELIP_LEN, ELIP_LEN, ELIP_CLS, "elip151")) begin
            v.kind = KIND_ELIP151;
        end else if (sig_hit(HEX_PRIV_LEN, HEX_PRIV_LEN, HEX_CLS, "")) begin
            v.kind = KIND_HEX_PRIV;
        end else if (sig_hit(HEX_PUB_LEN, HEX_PUB_LEN, HEX_CLS, "")) begin
            v.kind = KIND_HEX_PUB;
        end else begin
            v.status = ST_NOMATCH;
        end
        return v;
    endfunction

    function automatic void clear_token();
        tok_len     = '0;
        tok_classes = '0;
        for (int i = 0; i < PREFIX_CHARS; i++) tok_prefix[i] = '0;
    endfunction

    // token state update for one accepted request
    function automatic void track_request(logic [CHAR_W-1:0] c, logic eot);
        if (!eot && c != sep_char) begin
            if (tok_len < PREFIX_CHARS) tok_prefix[tok_len] = c;
            if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
            tok_classes = tok_classes | char_class(c);
        end else begin
            verdict_q.push_back(classify_token());
            verdicts_made++;
            clear_token();
        end
    endfunction

    // random byte from one of the allowed classes
    function automatic logic [CHAR_W-1:0] pick_char(logic [CLS_W-1:0] allowed);
        int b;
        logic [CHAR_W-1:0] c;
        b = $urandom_range(0, CLS_W-1);
        while (!allowed[b]) b = $urandom_range(0, CLS_W-1);
        case (b)
            0: c = CHAR_W'("0" + $urandom_range(0, 9));
            1: c = CHAR_W'("a" + $urandom_range(0, 5));
            2: c = CHAR_W'("g" + $urandom_range(0, 19));
            3: c = CHAR_W'("A" + $urandom_range(0, 5));
            4: c = CHAR_W'("G" + $urandom_range(0, 19));
            5: c = $urandom_range(0, 1) ? "(" : ")";
            default: begin
                c = CHAR_W'($urandom_range(0, 255));
                while (char_class(c) != CLS_OTHER) c = CHAR_W'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // sender idle gap, junk on the data lines
    task automatic idle_gap(int n);
        in_ch.valid       <= 1'b0;
        in_ch.char_code   <= CHAR_W'($urandom_range(0, 255));
        in_ch.end_of_text <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge clk);
    endtask

    // one character request, held until accepted, then burst bookkeeping
    task automatic send_request(logic [CHAR_W-1:0] c, logic eot);
        in_ch.valid       <= 1'b1;
        in_ch.char_code   <= c;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        track_request(c, eot);
        items_sent++;
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                idle_gap($urandom_range(1, gap_max));
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    // sender pause until every verdict has come back
    task automatic wait_for_verdicts();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(logic [CHAR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sep_char = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // one token of the given shape, optionally broken, then its closer
    task automatic send_token(token_shape_e shape, bit broken);
        logic [CHAR_W-1:0] body [$];
        logic [CLS_W-1:0]  allowed;
        logic [CLS_W-1:0]  bad_cls;
        string lit;
        int len;
        int idx;
        bit raw;
        lit     = "";
        raw     = 1'b0;
        allowed = ANY_CLS;
        case (shape)
            TOK_SLIP77:   begin lit = "slip77"; len = SLIP_LEN; allowed = SLIP_CLS; end
            TOK_XPUB:     begin
                lit = "xpub"; len = $urandom_range(EXT_LEN_LO, EXT_LEN_HI); allowed = B58_CLS;
            end
            TOK_XPRV:     begin
                lit = "xprv"; len = $urandom_range(EXT_LEN_LO, EXT_LEN_HI); allowed = B58_CLS;
            end
            TOK_ELIP151:  begin lit = "elip151"; len = ELIP_LEN; allowed = ELIP_CLS; end
            TOK_HEX_PRIV: begin len = HEX_PRIV_LEN; allowed = HEX_CLS; end
            TOK_HEX_PUB:  begin len = HEX_PUB_LEN; allowed = HEX_CLS; end
            TOK_SHORT:    len = $urandom_range(1, 9);
            TOK_NOISE:    begin len = $urandom_range(0, 6); raw = 1'b1; end
            default:      begin len = $urandom_range(250, 300); raw = 1'b1; end
        endcase
        for (int i = 0; i < len; i++) begin
            if (i < lit.len()) body.push_back(lit[i]);
            else if (raw) body.push_back(CHAR_W'($urandom_range(0, 255)));
            else body.push_back(pick_char(allowed));
        end
        // broken variants: wrong length, stray class, damaged prefix
        if (broken) begin
            case ($urandom_range(0, 3))
                0: if (body.size() > 0) void'(body.pop_back());
                1: body.push_back(pick_char(allowed));
                2: begin
                    bad_cls = ~allowed;
                    if (bad_cls == '0) bad_cls = CLS_OTHER;
                    idx = $urandom_range(0, body.size() - 1);
                    body[idx] = pick_char(bad_cls);
                end
                default: if (lit.len() > 0) begin
                    idx = $urandom_range(0, lit.len() - 1);
                    body[idx] ^= 8'h20;
                end
            endcase
        end
        foreach (body[i]) send_request(body[i], 1'b0);
        case ($urandom_range(0, 3))
            0: send_request(CHAR_W'($urandom_range(0, 255)), 1'b1);
            1: send_request(sep_char, 1'b1);
            default: send_request(sep_char, 1'b0);
        endcase
    endtask

    // random token stream, signature shapes at well_pct percent, the rest short, noise or long
    task automatic random_tokens(int n_items, int min_verdicts, int well_pct);
        int start_items;
        int start_verdicts;
        int r;
        start_items    = items_sent;
        start_verdicts = verdicts_made;
        while (items_sent - start_items < n_items
               || verdicts_made - start_verdicts < min_verdicts) begin
            r = $urandom_range(0, 99);
            if (r < well_pct) begin
                send_token(token_shape_e'($urandom_range(TOK_SLIP77, TOK_HEX_PUB)),
                           $urandom_range(0, 4) == 0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) send_token(TOK_SHORT, 1'b0);
                else if (r < 95) send_token(TOK_NOISE, 1'b0);
                else send_token(TOK_LONG, 1'b0);
            end
        end
    endtask

    // short directed tokens under the reset separator
    task automatic test_directed_tokens();
        gap_max = 3;
        rx_mode = RX_PATTERN;
        // empty token closed by the separator, then by the end marker
        send_request(",", 1'b0);
        send_request(",", 1'b1);
        // exact seven-character signature
        send_text("elip151");
        send_request(",", 1'b0);
        // short token against a prefix, end marker byte ignored
        send_text("eli");
        send_request("a", 1'b1);
        // zero byte in the last prefix slot
        send_text("elip15");
        send_request(8'h00, 1'b0);
        send_request(",", 1'b0);
        // every class once, top byte value as other
        send_request(8'hFF, 1'b0);
        send_text("9aZgA(");
        send_request(8'h00, 1'b1);
        wait_for_verdicts();
    endtask

    // signature tokens with and without idling
    task automatic test_signature_tokens();
        write_separator(SEP_RESET);
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        random_tokens(100, 2, 70);
        gap_max = 6;
        rx_mode = RX_MOSTLY;
        random_tokens(100, 2, 70);
        wait_for_verdicts();
    endtask

    // separator at its extremes and at a random value
    task automatic test_separator_values();
        logic [CHAR_W-1:0] values [3];
        values = '{8'h00, 8'hFF, 8'h00};
        values[2] = CHAR_W'($urandom_range(0, 255));
        foreach (values[i]) begin
            write_separator(values[i]);
            gap_max = 2 + i;
            rx_mode = rx_mode_e'(i + 1);
            random_tokens(30, 2, 40);
            wait_for_verdicts();
        end
    endtask

    // long receiver hold while the sender keeps offering requests
    task automatic test_output_hold();
        write_separator(";");
        gap_max  = 0;
        rx_mode  = RX_ALWAYS;
        hold_len = 80;
        random_tokens(30, 3, 0);
        // sender pause until every verdict has come back
        wait_for_verdicts();
        gap_max = 4;
        rx_mode = RX_PATTERN;
        random_tokens(30, 2, 50);
        wait_for_verdicts();
    endtask

    // mixed stream with a changing separator and stall mode
    task automatic test_random_mix();
        logic [CHAR_W-1:0] seps [5];
        seps = '{",", ";", ":", " ", "/"};
        for (int p = 0; p < 3; p++) begin
            write_separator(seps[$urandom_range(0, 4)]);
            gap_max = $urandom_range(0, 5);
            rx_mode = rx_mode_e'($urandom_range(RX_ALWAYS, RX_SPARSE));
            random_tokens(20, 2, 55);
            wait_for_verdicts();
        end
    endtask

    // receiver: stall pattern per mode, plus one counted hold-off
    initial begin : receiver
        int rx_tick;
        int hold_cnt;
        rx_tick = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rx_tick++;
            if (hold_len > 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
                out_ch.ready <= 1'b0;
                repeat (hold_cnt) @(posedge clk);
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_MOSTLY:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: out_ch.ready <= ((rx_tick % 9) < 5);
                    default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // verdict checker against the oldest expectation
    initial begin : verdict_checker
        verdict_t got;
        verdict_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                got.status = t_status'(out_ch.status);
                got.kind   = out_ch.key_kind;
                got.len    = out_ch.token_length;
                got.mask   = out_ch.class_mask;
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected verdict: status %0d kind %0d len %0d mask %h",
                                 got.status, got.kind, got.len, got.mask);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("verdict mismatch: exp status %0d kind %0d len %0d mask %h",
                                     want.status, want.kind, want.len, want.mask);
                            $display("                  got status %0d kind %0d len %0d mask %h",
                                     got.status, got.kind, got.len, got.mask);
                        end
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.char_code   <= '0;
        in_ch.end_of_text <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        items_sent    = 0;
        verdicts_made = 0;
        fail_count    = 0;
        gap_max       = 0;
        burst_left    = 0;
        hold_len      = 0;
        rx_mode       = RX_ALWAYS;
        sep_char      = SEP_RESET;
        clear_token();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_tokens();
        test_signature_tokens();
        test_separator_values();
        test_output_hold();
        test_random_mix();

        wait_for_verdicts();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ktc_pkg.sv
hw/rtl/ktc_if.sv
hw/rtl/key_token_classifier_core.sv
verif/key_token_classifier_core_tb.sv
